// ===== hdl/kmc_pkg.sv =====
// Shared constants, types and state encodings for the k-means cluster block.
package kmc_pkg;

  localparam int NUM_CLUSTERS = 4;
  localparam int MAX_POINTS   = 1024;
  localparam int COORD_W      = 32;
  localparam int FRAC_W       = 16;
  localparam int IDX_W        = 4;
  localparam int PASS_W       = 8;
  localparam logic [PASS_W-1:0] PASS_RESET = 8'd10;
  localparam int QUEUE_DEPTH  = 2;
  localparam int DIST_W       = COORD_W + 2;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_LOAD_RUN = 2'd1,
    OP_EVAL     = 2'd2
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e            op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] cluster_index;
    logic             train_done;
    logic             overflow;
  } res_t;

  typedef enum logic [3:0] {
    BK_IDLE  = 4'd0,
    BK_NEAR  = 4'd1,
    BK_ACC   = 4'd2,
    BK_PASS  = 4'd3,
    BK_LATCH = 4'd4,
    BK_UPD   = 4'd5,
    BK_DIVX  = 4'd6,
    BK_DIVY  = 4'd7,
    BK_DONE  = 4'd8
  } back_state_e;

endpackage

// ===== hdl/kmc_fifo.sv =====
// Small first-in first-out queue built from flip-flops.
module kmc_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = kmc_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [AW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/kmc_front.sv =====
// Input side: classifies each incoming item and queues it as a command.
module kmc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic                          req_type_i,
  input  logic [kmc_pkg::COORD_W-1:0]   x_coord_i,
  input  logic [kmc_pkg::COORD_W-1:0]   y_coord_i,
  input  logic                          last_i,
  output logic                          cmd_valid_o,
  output kmc_pkg::cmd_t                 cmd_o,
  input  logic                          cmd_pop_i
);

  kmc_pkg::cmd_t in_cmd;
  logic          cmd_empty;

  // The last flag only matters on a training point.
  always_comb begin
    in_cmd.x = x_coord_i;
    in_cmd.y = y_coord_i;
    if (req_type_i) begin
      in_cmd.op = kmc_pkg::OP_EVAL;
    end else if (last_i) begin
      in_cmd.op = kmc_pkg::OP_LOAD_RUN;
    end else begin
      in_cmd.op = kmc_pkg::OP_LOAD;
    end
  end

  kmc_fifo #(
    .WIDTH($bits(kmc_pkg::cmd_t)),
    .DEPTH(kmc_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (in_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_o),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

// ===== hdl/kmc_div.sv =====
// Signed-by-unsigned restoring divider, one quotient bit per cycle, floored result.
module kmc_div #(
  parameter int NUM_W = 43,
  parameter int DEN_W = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [NUM_W-1:0]              num_i,
  input  logic [DEN_W-1:0]              den_i,
  output logic                          done_o,
  output logic [kmc_pkg::COORD_W-1:0]   quot_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_q, done_q, neg_q;
  logic [CW-1:0]    cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic [NUM_W-1:0] floored;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NUM_W-1];
      quo_q <= num_i[NUM_W-1] ? (~num_i + 1'b1) : num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], fits};
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // A negative dividend rounds toward minus infinity: -q, less one if a remainder is left.
  assign floored = neg_q ? (~quo_q + NUM_W'(rem_q == '0)) : quo_q;
  assign quot_o  = floored[kmc_pkg::COORD_W-1:0];
  assign done_o  = done_q;

endmodule

// ===== hdl/kmc_back.sv =====
// Command engine: point store, centroid search, training passes and result issue.
module kmc_back #(
  parameter int NUM_CLUSTERS = kmc_pkg::NUM_CLUSTERS,
  parameter int MAX_POINTS   = kmc_pkg::MAX_POINTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [kmc_pkg::PASS_W-1:0]    pass_count_i,
  input  logic                          cmd_valid_i,
  input  kmc_pkg::cmd_t                 cmd_i,
  output logic                          cmd_pop_o,
  input  logic                          res_full_i,
  output logic                          res_push_o,
  output kmc_pkg::res_t                 res_o
);

  localparam int CW    = kmc_pkg::COORD_W;
  localparam int CIW   = $clog2(NUM_CLUSTERS);
  localparam int KW    = $clog2(NUM_CLUSTERS + 1);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int PAW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int SUM_W = CW + CNT_W;
  localparam int DW    = kmc_pkg::DIST_W;

  kmc_pkg::back_state_e state_q, state_d;

  logic [KW-1:0]     k_q;
  logic [CNT_W-1:0]  p_q, loaded_q;
  logic              ovf_q, eval_q;
  logic [kmc_pkg::PASS_W-1:0] passes_q;
  logic [CW-1:0]     pt_x_q, pt_y_q;
  logic [DW-1:0]     best_q;
  logic [CIW-1:0]    bidx_q;
  logic [CW-1:0]     cx_q [NUM_CLUSTERS];
  logic [CW-1:0]     cy_q [NUM_CLUSTERS];
  logic [SUM_W-1:0]  sx_q [NUM_CLUSTERS];
  logic [SUM_W-1:0]  sy_q [NUM_CLUSTERS];
  logic [CNT_W-1:0]  cnt_q [NUM_CLUSTERS];
  logic [2*CW-1:0]   mem_q [MAX_POINTS];
  logic [2*CW-1:0]   rd_q;

  logic [CIW-1:0]    kc;
  logic [CW:0]       dx, dy;
  logic [CW-1:0]     ax, ay;
  logic [DW-1:0]     sum_dist;
  logic              better, last_k, k_end, store_room, pt_pending;
  logic [CIW-1:0]    fin_idx;

  logic              mem_we, div_start, div_done;
  logic [SUM_W-1:0]  div_num;
  logic [CW-1:0]     div_quot;

  assign kc     = k_q[CIW-1:0];
  assign dx     = {pt_x_q[CW-1], pt_x_q} - {cx_q[kc][CW-1], cx_q[kc]};
  assign dy     = {pt_y_q[CW-1], pt_y_q} - {cy_q[kc][CW-1], cy_q[kc]};
  assign ax     = dx[CW] ? CW'(-dx) : dx[CW-1:0];
  assign ay     = dy[CW] ? CW'(-dy) : dy[CW-1:0];
  assign sum_dist = {2'b00, ax} + {2'b00, ay};
  assign better = (k_q == '0) || (sum_dist < best_q);
  assign last_k = (k_q == KW'(NUM_CLUSTERS - 1));
  assign k_end  = (k_q == KW'(NUM_CLUSTERS));
  assign fin_idx = better ? kc : bidx_q;
  assign store_room = (loaded_q < CNT_W'(MAX_POINTS));
  assign pt_pending = (p_q < loaded_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kmc_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            kmc_pkg::OP_EVAL:     state_d = kmc_pkg::BK_NEAR;
            kmc_pkg::OP_LOAD_RUN: state_d = (pass_count_i == '0) ? kmc_pkg::BK_DONE
                                                                 : kmc_pkg::BK_PASS;
            default:              state_d = kmc_pkg::BK_IDLE;
          endcase
        end
      end
      kmc_pkg::BK_NEAR: begin
        if (last_k) begin
          if (!eval_q) begin
            state_d = kmc_pkg::BK_ACC;
          end else if (!res_full_i) begin
            state_d = kmc_pkg::BK_IDLE;
          end
        end
      end
      kmc_pkg::BK_ACC:   state_d = kmc_pkg::BK_PASS;
      kmc_pkg::BK_PASS:  state_d = pt_pending ? kmc_pkg::BK_LATCH : kmc_pkg::BK_UPD;
      kmc_pkg::BK_LATCH: state_d = kmc_pkg::BK_NEAR;
      kmc_pkg::BK_UPD: begin
        if (k_end) begin
          state_d = (passes_q == kmc_pkg::PASS_W'(1)) ? kmc_pkg::BK_DONE : kmc_pkg::BK_PASS;
        end else if (cnt_q[kc] != '0) begin
          state_d = kmc_pkg::BK_DIVX;
        end
      end
      kmc_pkg::BK_DIVX: if (div_done) state_d = kmc_pkg::BK_DIVY;
      kmc_pkg::BK_DIVY: if (div_done) state_d = kmc_pkg::BK_UPD;
      kmc_pkg::BK_DONE: if (!res_full_i) state_d = kmc_pkg::BK_IDLE;
      default:          state_d = kmc_pkg::BK_IDLE;
    endcase
  end

  // Strobes and result payload.
  always_comb begin
    cmd_pop_o  = (state_q == kmc_pkg::BK_IDLE) && cmd_valid_i;
    mem_we     = cmd_pop_o && (cmd_i.op != kmc_pkg::OP_EVAL) && store_room;
    res_push_o = 1'b0;
    res_o      = '0;
    div_start  = 1'b0;
    div_num    = sx_q[kc];
    unique case (state_q)
      kmc_pkg::BK_NEAR: begin
        res_push_o          = last_k && eval_q && !res_full_i;
        res_o.cluster_index = kmc_pkg::IDX_W'(fin_idx);
      end
      kmc_pkg::BK_UPD: begin
        div_start = !k_end && (cnt_q[kc] != '0);
      end
      kmc_pkg::BK_DIVX: begin
        div_start = div_done;
        div_num   = sy_q[kc];
      end
      kmc_pkg::BK_DONE: begin
        res_push_o     = !res_full_i;
        res_o.train_done = 1'b1;
        res_o.overflow = ovf_q;
      end
      default: ;
    endcase
  end

  // Point store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[loaded_q[PAW-1:0]] <= {cmd_i.x, cmd_i.y};
    end
    rd_q <= mem_q[p_q[PAW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= kmc_pkg::BK_IDLE;
      k_q      <= '0;
      p_q      <= '0;
      loaded_q <= '0;
      ovf_q    <= 1'b0;
      eval_q   <= 1'b0;
      passes_q <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        kmc_pkg::BK_IDLE: begin
          if (cmd_pop_o) begin
            k_q <= '0;
            if (cmd_i.op == kmc_pkg::OP_EVAL) begin
              eval_q <= 1'b1;
            end else begin
              if (store_room) begin
                loaded_q <= loaded_q + 1'b1;
              end else begin
                ovf_q <= 1'b1;
              end
              if (cmd_i.op == kmc_pkg::OP_LOAD_RUN) begin
                eval_q   <= 1'b0;
                passes_q <= pass_count_i;
                p_q      <= '0;
              end
            end
          end
        end
        kmc_pkg::BK_NEAR:  if (!last_k) k_q <= k_q + 1'b1;
        kmc_pkg::BK_ACC:   p_q <= p_q + 1'b1;
        kmc_pkg::BK_PASS:  k_q <= '0;
        kmc_pkg::BK_LATCH: k_q <= '0;
        kmc_pkg::BK_UPD: begin
          if (k_end) begin
            passes_q <= passes_q - 1'b1;
            p_q      <= '0;
          end else if (cnt_q[kc] == '0) begin
            k_q <= k_q + 1'b1;
          end
        end
        kmc_pkg::BK_DIVY: if (div_done) k_q <= k_q + 1'b1;
        kmc_pkg::BK_DONE: begin
          if (!res_full_i) begin
            loaded_q <= '0;
            ovf_q    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Point under test and running minimum.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && (cmd_i.op == kmc_pkg::OP_EVAL)) begin
      pt_x_q <= cmd_i.x;
      pt_y_q <= cmd_i.y;
    end else if (state_q == kmc_pkg::BK_LATCH) begin
      pt_x_q <= rd_q[2*CW-1:CW];
      pt_y_q <= rd_q[CW-1:0];
    end
    if ((state_q == kmc_pkg::BK_NEAR) && better) begin
      best_q <= sum_dist;
      bidx_q <= kc;
    end
  end

  // Centroids start from zero so an eval before any training picks index zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLUSTERS; i++) begin
        cx_q[i] <= '0;
        cy_q[i] <= '0;
      end
    end else if (cmd_pop_o && (cmd_i.op == kmc_pkg::OP_LOAD_RUN)) begin
      for (int i = 0; i < NUM_CLUSTERS; i++) begin
        cx_q[i] <= CW'(i) << kmc_pkg::FRAC_W;
        cy_q[i] <= CW'(i) << kmc_pkg::FRAC_W;
      end
    end else if ((state_q == kmc_pkg::BK_DIVX) && div_done) begin
      cx_q[kc] <= div_quot;
    end else if ((state_q == kmc_pkg::BK_DIVY) && div_done) begin
      cy_q[kc] <= div_quot;
    end
  end

  // Per-cluster sums; a cluster is cleared once its new centroid is written.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && (cmd_i.op == kmc_pkg::OP_LOAD_RUN)) begin
      for (int i = 0; i < NUM_CLUSTERS; i++) begin
        sx_q[i]  <= '0;
        sy_q[i]  <= '0;
        cnt_q[i] <= '0;
      end
    end else if (state_q == kmc_pkg::BK_ACC) begin
      sx_q[bidx_q]  <= sx_q[bidx_q] + {{(SUM_W-CW){pt_x_q[CW-1]}}, pt_x_q};
      sy_q[bidx_q]  <= sy_q[bidx_q] + {{(SUM_W-CW){pt_y_q[CW-1]}}, pt_y_q};
      cnt_q[bidx_q] <= cnt_q[bidx_q] + 1'b1;
    end else if ((state_q == kmc_pkg::BK_DIVY) && div_done) begin
      sx_q[kc]  <= '0;
      sy_q[kc]  <= '0;
      cnt_q[kc] <= '0;
    end
  end

  kmc_div #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (cnt_q[kc]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

endmodule

// ===== hdl/kmeans_manhattan_cluster_top.sv =====
// Top level of the k-means cluster block with Manhattan distance.
//
//   Channel   Handshake            Payload
//   input     push / full          req_type_i, x_coord_i, y_coord_i, last_i
//   result    empty / pop          cluster_index_o, train_done_o, overflow_o
//   config    cfg_we_i             cfg_wdata_i (pass count)
//
// A training point is stored when the engine takes it from the input queue. For an eval
// item the search visits one centroid per cycle; a full result queue holds its result.
// A training run makes pass_count passes; each pass searches and accumulates every stored
// point, then divides the sums of each nonempty cluster, with a 43-bit sum width;
// the shared serial divider sets most of the run time.
// Reset clears the queues, the centroids and the pass count (to ten).
// Input and result queues of two entries let each side stall independently.
module kmeans_manhattan_cluster_top #(
  parameter int NUM_CLUSTERS = kmc_pkg::NUM_CLUSTERS,
  parameter int MAX_POINTS   = kmc_pkg::MAX_POINTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic                          req_type_i,
  input  logic [kmc_pkg::COORD_W-1:0]   x_coord_i,
  input  logic [kmc_pkg::COORD_W-1:0]   y_coord_i,
  input  logic                          last_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [kmc_pkg::IDX_W-1:0]     cluster_index_o,
  output logic                          train_done_o,
  output logic                          overflow_o,
  input  logic                          cfg_we_i,
  input  logic [kmc_pkg::PASS_W-1:0]    cfg_wdata_i
);

  logic [kmc_pkg::PASS_W-1:0] pass_count_q;
  logic                       cmd_valid, cmd_pop, res_full, res_push;
  kmc_pkg::cmd_t              cmd;
  kmc_pkg::res_t              res_in, res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_count_q <= kmc_pkg::PASS_RESET;
    end else if (cfg_we_i) begin
      pass_count_q <= cfg_wdata_i;
    end
  end

  kmc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_type_i  (req_type_i),
    .x_coord_i   (x_coord_i),
    .y_coord_i   (y_coord_i),
    .last_i      (last_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  kmc_back #(
    .NUM_CLUSTERS(NUM_CLUSTERS),
    .MAX_POINTS  (MAX_POINTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pass_count_i (pass_count_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  kmc_fifo #(
    .WIDTH($bits(kmc_pkg::res_t)),
    .DEPTH(kmc_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign cluster_index_o = res_out.cluster_index;
  assign train_done_o    = res_out.train_done;
  assign overflow_o      = res_out.overflow;

endmodule
